FILE: hdl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg: shared types for the timestamp sorter
// Request/response payloads and the entry/control records of the sort chain.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int KEY_BITS = 40;
   localparam int TAG_BITS = 16;

   typedef struct packed {
      logic [KEY_BITS-1:0] time_key;
      logic [TAG_BITS-1:0] entry_tag;
      logic                last_entry;
   } req_payload_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] sorted_key;
      logic [TAG_BITS-1:0] sorted_tag;
      logic                last_result;
      logic                overflowed;
   } rsp_payload_type;

   // one slot of the sort chain
   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } cell_data_type;

   // chain-wide command, at most one bit set per cycle
   typedef struct packed {
      logic insert;    // place the new entry, cells after it move up one
      logic shift_dn;  // every cell takes its higher-index neighbor
      logic shift_up;  // every cell takes its lower-index neighbor
   } cell_ctl_type;

endpackage

FILE: hdl/tss_cell.sv
// ----------------------------------------------------------------------------
// tss_cell: one slot of the insertion sort chain
// Holds one entry; takes the new entry, a neighbor's entry, or keeps its own.
// ----------------------------------------------------------------------------
module tss_cell
   import tss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  cell_data_type new_data,
   input  cell_data_type prev_data,
   input  logic          prev_ins,
   input  cell_data_type next_data,
   output cell_data_type own_data,
   output logic          own_ins
);

   cell_data_type entry_ff;
   cell_data_type entry_in;

   // strict compare keeps equal times in arrival order
   assign own_ins  = !entry_ff.valid || (new_data.key > entry_ff.key);
   assign own_data = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (own_ins) begin
            entry_in = prev_ins ? prev_data : new_data;
         end
      end else if (ctl.shift_dn) begin
         entry_in = next_data;
      end else if (ctl.shift_up) begin
         entry_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

FILE: hdl/timestamp_sorter_with_reverse.sv
// ----------------------------------------------------------------------------
// timestamp_sorter_with_reverse: stable newest-first sorter with reversal
// Systolic insertion chain of MAX_ENTRIES cells; batch drains after the mark.
// ----------------------------------------------------------------------------
// Fill: one request per cycle, each placed in the chain as it lands unless full.
// Drain: the first result follows the marked request through the state and
//   output registers; then one result per cycle newest-first, or oldest-first
//   after the chain shifts MAX_ENTRIES-n places to the output end. Response
//   stalls stretch the drain. Requests are stalled while the chain drains.
// Reset: chain valid bits, counters and csr cleared at once, no sweep.
// ----------------------------------------------------------------------------
module timestamp_sorter_with_reverse
   import tss_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_en,
   input  logic            csr_write_data
);

   localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);

   typedef enum logic {ST_FILL, ST_DRAIN} state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;   // entries stored in the batch being filled
   logic [CNT_BITS-1:0]   left_ff, left_in;     // results still to emit
   logic                  ovf_ff, ovf_in;       // current batch dropped something
   logic                  batch_ovf_ff, batch_ovf_in;
   logic                  dir_up_ff, dir_up_in; // oldest-first drain
   logic                  oldest_first_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   cell_ctl_type          ctl;
   cell_data_type         new_data;
   cell_data_type         empty_data;
   cell_data_type         cell_q [MAX_ENTRIES];
   logic                  cell_ins [MAX_ENTRIES];
   cell_data_type         src;

   logic req_fire;
   logic room;
   logic advance;
   logic emit;

   assign req_stall   = (state_ff == ST_DRAIN);
   assign req_fire    = req_valid && !req_stall;
   assign room        = (count_ff < CNT_BITS'(MAX_ENTRIES));
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // output register free to take the next result
   assign advance = !rsp_valid_ff || !rsp_stall;

   // newest-first drains from the head, oldest-first from the tail
   assign src  = dir_up_ff ? cell_q[MAX_ENTRIES-1] : cell_q[0];
   assign emit = (state_ff == ST_DRAIN) && advance && src.valid;

   assign new_data.valid = 1'b1;
   assign new_data.key   = req_payload.time_key;
   assign new_data.tag   = req_payload.entry_tag;

   assign empty_data = '0;

   // ---- chain command ----
   always_comb begin
      ctl          = '0;
      ctl.insert   = req_fire && room;
      ctl.shift_dn = (state_ff == ST_DRAIN) && advance && !dir_up_ff;
      ctl.shift_up = (state_ff == ST_DRAIN) && advance && dir_up_ff;
   end

   // ---- the chain ----
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      cell_data_type prev_d;
      cell_data_type next_d;
      logic          prev_i;

      if (i == 0) begin : g_head
         assign prev_d = empty_data;
         assign prev_i = 1'b0;
      end else begin : g_body
         assign prev_d = cell_q[i-1];
         assign prev_i = cell_ins[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign next_d = empty_data;
      end else begin : g_inner
         assign next_d = cell_q[i+1];
      end

      tss_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_data  (new_data),
         .prev_data (prev_d),
         .prev_ins  (prev_i),
         .next_data (next_d),
         .own_data  (cell_q[i]),
         .own_ins   (cell_ins[i])
      );
   end

   // ---- control next state ----
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      left_in        = left_ff;
      ovf_in         = ovf_ff;
      batch_ovf_in   = batch_ovf_ff;
      dir_up_in      = dir_up_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      unique case (state_ff)
         ST_FILL: begin
            if (req_fire) begin
               if (room) begin
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.last_entry) begin
                  // batch closes: count includes the marked request if stored
                  state_in     = ST_DRAIN;
                  left_in      = count_ff + CNT_BITS'(room);
                  batch_ovf_in = ovf_ff || !room;
                  dir_up_in    = oldest_first_ff;
                  count_in     = '0;
                  ovf_in       = 1'b0;
               end
            end
         end
         ST_DRAIN: begin
            if (emit) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.sorted_key  = src.key;
               rsp_payload_in.sorted_tag  = src.tag;
               rsp_payload_in.last_result = (left_ff == CNT_BITS'(1));
               rsp_payload_in.overflowed  = batch_ovf_ff;
               left_in                    = left_ff - CNT_BITS'(1);
               if (left_ff == CNT_BITS'(1)) begin
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_FILL;
         count_ff        <= '0;
         left_ff         <= '0;
         ovf_ff          <= 1'b0;
         batch_ovf_ff    <= 1'b0;
         dir_up_ff       <= 1'b0;
         oldest_first_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         ovf_ff       <= ovf_in;
         batch_ovf_ff <= batch_ovf_in;
         dir_up_ff    <= dir_up_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            oldest_first_ff <= csr_write_data;
         end
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_ENTRIES))
      else $error("entry count beyond chain depth");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && count_ff == '0) |-> !cell_q[0].valid)
      else $error("chain not empty at start of batch");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && !dir_up_ff) |-> cell_q[0].valid)
      else $error("newest-first drain ran out of entries");

   a_drain_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (left_ff != '0))
      else $error("drain with nothing left to emit");

endmodule

FILE: tb/tb_timestamp_sorter_with_reverse.sv
// ----------------------------------------------------------------------------
// tb_timestamp_sorter_with_reverse: self-checking bench for the stable sorter
// Drives batches of timestamped entries, predicts the sorted output batch
// (newest first, or reversed when oldest_first is set), including capacity
// overflow, and checks each response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_timestamp_sorter_with_reverse
   import tss_pkg::*;
();

   localparam int MAX_ENTRIES   = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int ROW_COUNT     = 19;

   localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
   localparam logic [TAG_BITS-1:0] TAG_MAX = '1;

   // one row of the directed table; result is used only when typed is set
   typedef struct packed {
      req_payload_type req;
      logic            typed;
      rsp_payload_type result;
   } directed_row_type;

   // Directed requests. Single-entry batches have their result typed in;
   // the multi-entry batches (ties, bit patterns, ordered input) go through
   // the predictor.
   localparam directed_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      // one-entry batch, all zeros
      '{'{40'h00_0000_0000, 16'h0000, 1'b1}, 1'b1, '{40'h00_0000_0000, 16'h0000, 1'b1, 1'b0}},
      // one-entry batch, all ones
      '{'{KEY_MAX, TAG_MAX, 1'b1}, 1'b1, '{KEY_MAX, TAG_MAX, 1'b1, 1'b0}},
      // equal times must keep arrival order
      '{'{40'h00_0000_0005, 16'h0001, 1'b0}, 1'b0, '0},
      '{'{40'h00_0000_0009, 16'h0002, 1'b0}, 1'b0, '0},
      '{'{40'h00_0000_0005, 16'h0003, 1'b0}, 1'b0, '0},
      '{'{40'h00_0000_0009, 16'h0004, 1'b1}, 1'b0, '0},
      // alternating bit patterns
      '{'{40'hAA_AAAA_AAAA, 16'h5555, 1'b0}, 1'b0, '0},
      '{'{40'h55_5555_5555, 16'hAAAA, 1'b0}, 1'b0, '0},
      '{'{40'h00_0000_0000, 16'h0000, 1'b1}, 1'b0, '0},
      // already newest first
      '{'{KEY_MAX,          16'h0001, 1'b0}, 1'b0, '0},
      '{'{40'h80_0000_0000, 16'h0002, 1'b0}, 1'b0, '0},
      '{'{40'h00_0000_0001, 16'h0003, 1'b0}, 1'b0, '0},
      '{'{40'h00_0000_0000, 16'h0004, 1'b1}, 1'b0, '0},
      // oldest first on input
      '{'{40'h00_0000_0001, 16'h0010, 1'b0}, 1'b0, '0},
      '{'{40'h00_0000_0002, 16'h0020, 1'b0}, 1'b0, '0},
      '{'{KEY_MAX,          16'h0030, 1'b1}, 1'b0, '0},
      // all times equal
      '{'{40'h00_0000_0007, 16'h0100, 1'b0}, 1'b0, '0},
      '{'{40'h00_0000_0007, 16'h0101, 1'b0}, 1'b0, '0},
      '{'{40'h00_0000_0007, 16'h0102, 1'b1}, 1'b0, '0}
   };

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_write_en;
   logic            csr_write_data;

   // sorter state as the bench sees it
   logic [KEY_BITS-1:0] held_keys [MAX_ENTRIES];
   logic [TAG_BITS-1:0] held_tags [MAX_ENTRIES];
   int                  held_count;
   bit                  dropped_any;
   bit                  oldest_first_cfg;

   // results still owed by the block, oldest at the front
   rsp_payload_type pending_sorted[$];

   // idle percentages, changed per phase
   int req_idle_pct;
   int rsp_idle_pct;

   int cycle_count;
   int mismatch_count;
   int requests_sent;
   int results_seen;
   int batches_sent;
   int overflow_batches;
   int reversed_batches;

   timestamp_sorter_with_reverse #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Take one accepted request into the bench's copy of the sorter. On the
   // marked entry, sort the stored entries stably newest first, reverse if
   // configured, and append the whole batch to out_q.
   function automatic void predict_sorted_batch(input req_payload_type r,
                                                ref rsp_payload_type out_q[$]);
      logic [KEY_BITS-1:0] keys [MAX_ENTRIES];
      logic [TAG_BITS-1:0] tags [MAX_ENTRIES];
      logic [KEY_BITS-1:0] k;
      logic [TAG_BITS-1:0] t;
      rsp_payload_type     rsp;
      int                  j;
      int                  src;
      if (held_count < MAX_ENTRIES) begin
         held_keys[held_count] = r.time_key;
         held_tags[held_count] = r.entry_tag;
         held_count++;
      end else begin
         // full store: drop, even the marked entry
         dropped_any = 1'b1;
      end
      if (!r.last_entry) return;

      keys = held_keys;
      tags = held_tags;
      // insertion sort; strict compare keeps equal times in arrival order
      for (int i = 1; i < held_count; i++) begin
         k = keys[i];
         t = tags[i];
         j = i;
         while (j > 0 && keys[j-1] < k) begin
            keys[j] = keys[j-1];
            tags[j] = tags[j-1];
            j--;
         end
         keys[j] = k;
         tags[j] = t;
      end
      for (int p = 0; p < held_count; p++) begin
         src = oldest_first_cfg ? held_count - 1 - p : p;
         rsp.sorted_key  = keys[src];
         rsp.sorted_tag  = tags[src];
         rsp.last_result = (p == held_count - 1);
         rsp.overflowed  = dropped_any;
         out_q.push_back(rsp);
      end
      batches_sent++;
      if (dropped_any) overflow_batches++;
      if (oldest_first_cfg) reversed_batches++;
      held_count  = 0;
      dropped_any = 1'b0;
   endfunction

   // Offer one request, with a random gap first, and wait for it to be taken.
   // Called right after a rising edge; returns at the edge that accepted it.
   task automatic send_request(input req_payload_type r, input bit typed,
                               input rsp_payload_type typed_rsp);
      rsp_payload_type batch_q[$];
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_sorted_batch(r, batch_q);
      // a typed row stands in for the predicted single-entry batch
      if (typed) pending_sorted.push_back(typed_rsp);
      else foreach (batch_q[i]) pending_sorted.push_back(batch_q[i]);
      requests_sent++;
   endtask

   // Hold the sender off until every owed result has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_oldest_first(input bit value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en     <= 1'b0;
      oldest_first_cfg  = value;
   endtask

   // Mix of extremes, a few small values for ties, and full-range times.
   function automatic logic [KEY_BITS-1:0] random_time_key();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return KEY_MAX;
         2, 3, 4: return KEY_BITS'($urandom_range(0, 7));
         default: return wide[KEY_BITS-1:0];
      endcase
   endfunction

   task automatic send_random_batch(input int size);
      req_payload_type r;
      for (int i = 0; i < size; i++) begin
         r.time_key   = random_time_key();
         r.entry_tag  = TAG_BITS'($urandom);
         r.last_entry = (i == size - 1);
         send_request(r, 1'b0, '0);
      end
   endtask

   task automatic walk_directed_table();
      foreach (DIRECTED_ROWS[i])
         send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].result);
   endtask

   // Mostly short batches; now and then a medium one, or one near or past
   // capacity so the overflow flag and the dropped mark get exercised.
   task automatic run_random_batches(input int item_goal);
      int sent;
      int size;
      int pick;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)     size = $urandom_range(MAX_ENTRIES - 4, MAX_ENTRIES + 6);
         else if (pick < 3) size = $urandom_range(9, 24);
         else               size = $urandom_range(1, 8);
         send_random_batch(size);
         sent += size;
         // occasional full pause between batches
         if ($urandom_range(0, 9) == 0) wait_for_drain();
      end
      wait_for_drain();
   endtask

   // Response side: random stall and in-order check against the owed results.
   always @(posedge clock) begin : response_check
      rsp_payload_type want;
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         results_seen++;
         if (pending_sorted.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("[%0d] unexpected response key=%h tag=%h last=%b ovf=%b",
                        cycle_count, rsp_payload.sorted_key, rsp_payload.sorted_tag,
                        rsp_payload.last_result, rsp_payload.overflowed);
         end else begin
            want = pending_sorted.pop_front();
            if (rsp_payload !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("[%0d] mismatch: expected key=%h tag=%h last=%b ovf=%b",
                           cycle_count, want.sorted_key, want.sorted_tag,
                           want.last_result, want.overflowed);
                  $display("[%0d]           got key=%h tag=%h last=%b ovf=%b",
                           cycle_count, rsp_payload.sorted_key, rsp_payload.sorted_tag,
                           rsp_payload.last_result, rsp_payload.overflowed);
               end
            end
         end
      end
   end

   // Watchdog: far above the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, pending_sorted.size());
         $display("** timestamp_sorter_with_reverse: FAILED **");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload      <= '0;
      rsp_stall        <= 1'b0;
      csr_write_en     <= 1'b0;
      csr_write_data   <= 1'b0;
      req_idle_pct      = 0;
      rsp_idle_pct      = 0;
      cycle_count       = 0;
      mismatch_count    = 0;
      requests_sent     = 0;
      results_seen      = 0;
      batches_sent      = 0;
      overflow_batches  = 0;
      reversed_batches  = 0;
      held_count        = 0;
      dropped_any       = 1'b0;
      oldest_first_cfg  = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase 1: sender idles a little, receiver a lot; newest first.
      req_idle_pct = 22;
      rsp_idle_pct = 70;
      write_oldest_first(1'b0);
      walk_directed_table();
      send_random_batch(MAX_ENTRIES);      // exactly full, no overflow
      run_random_batches(20);

      // Phase 2: the other way round; oldest first.
      req_idle_pct = 70;
      rsp_idle_pct = 22;
      write_oldest_first(1'b1);
      walk_directed_table();
      send_random_batch(MAX_ENTRIES + 1);  // marked entry dropped, reversed
      run_random_batches(20);

      // Phase 3: no idling on either side, both orders.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_oldest_first(1'b0);
      run_random_batches(15);
      write_oldest_first(1'b1);
      run_random_batches(15);

      // wait_for_drain already settled; a little more for stray responses
      repeat (20) @(posedge clock);

      $display("covered %0d requests in %0d batches (%0d reversed, %0d overflowed)",
               requests_sent, batches_sent, reversed_batches, overflow_batches);
      $display("checked %0d results, %0d mismatches", results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("** timestamp_sorter_with_reverse: PASSED **");
      end else begin
         $display("** timestamp_sorter_with_reverse: FAILED **");
      end
      $finish;
   end

endmodule
